// ===== hdl/uapq_pkg.sv =====
package uapq_pkg;

   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 31;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [RANK_W-1:0]         rank_type;
   typedef logic [STAT_W-1:0]         status_type;
   typedef logic [OCC_W-1:0]          occ_type;

   localparam cmd_type CMD_PUSH = 2'd0;
   localparam cmd_type CMD_POP  = 2'd1;
   localparam cmd_type CMD_PEEK = 2'd2;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;

   typedef struct packed {
      cmd_type   command;
      value_type value;
      rank_type  priority_req;
   } req_payload_type;

   typedef struct packed {
      value_type  result_value;
      status_type status;
      occ_type    occupancy;
   } rsp_payload_type;

   // One stored queue entry.
   typedef struct packed {
      rank_type  rank;
      value_type value;
   } entry_type;

   // Control from the sequencer to the max tracker.
   typedef struct packed {
      logic sample;
      logic first;
   } scan_ctl_type;

endpackage

// ===== hdl/uapq_max_track.sv =====
module uapq_max_track #(
   parameter int IDX_W = 4
) (
   input  logic                    clock,
   input  uapq_pkg::scan_ctl_type  scan_ctl,
   input  uapq_pkg::entry_type     entry,
   input  logic [IDX_W-1:0]        entry_idx,
   output uapq_pkg::value_type     best_value,
   output logic [IDX_W-1:0]        best_idx
);

   uapq_pkg::rank_type  best_rank_ff;
   uapq_pkg::value_type best_value_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic                take;

   // Strictly greater keeps the oldest entry among equal ranks.
   assign take = scan_ctl.sample && (scan_ctl.first || (entry.rank > best_rank_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_rank_ff  <= entry.rank;
         best_value_ff <= entry.value;
         best_idx_ff   <= entry_idx;
      end
   end

   assign best_value = best_value_ff;
   assign best_idx   = best_idx_ff;

endmodule

// ===== hdl/unsorted_array_max_priority_queue.sv =====
// Max-priority queue kept as an unsorted array of (value, rank) entries.
// Input channel req_*: one command per transfer (push, pop greatest, peek
// greatest). Result channel rsp_*: exactly one result per command, holding
// the popped or peeked value, a status code and the occupancy afterwards.
// The block takes one command at a time; req_ready is high only while idle.
// Push, full push, empty pop/peek and unused codes go straight to the finish
// state. Peek scans all held entries, then finishes. Pop scans, then shifts
// the entries above the chosen one down by one place, then finishes.
// Scan and shift speed is set by the entry memory's single read port: the scan
// reads one entry per cycle into one rank comparator, and the shift that
// closes the gap moves one entry per cycle. The next command is taken in the
// cycle after the result is loaded into the output register, even while
// rsp_valid is still waiting for rsp_ready; if the receiver stalls, the
// following result waits in its final state until the output register frees up.
// A synchronous reset empties the queue and drops any pending result.
module unsorted_array_max_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  uapq_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output uapq_pkg::rsp_payload_type rsp_payload
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      pipe_valid_ff, pipe_valid_in;
   logic [ADDR_W-1:0]         pipe_idx_ff, pipe_idx_in;
   uapq_pkg::cmd_type         cmd_ff, cmd_in;
   uapq_pkg::value_type       res_value_ff, res_value_in;
   uapq_pkg::status_type      res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   uapq_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   uapq_pkg::entry_type       mem [DEPTH];
   uapq_pkg::entry_type       rd_data_ff;
   uapq_pkg::entry_type       mem_wdata;
   logic [ADDR_W-1:0]         mem_waddr;
   logic                      mem_we;

   uapq_pkg::scan_ctl_type    scan_ctl;
   uapq_pkg::value_type       best_value;
   logic [ADDR_W-1:0]         best_idx;
   logic                      req_fire;
   logic                      issue;
   logic                      drained;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign issue   = (idx_ff < count_ff);
   assign drained = (idx_ff == count_ff) && !pipe_valid_ff;

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   uapq_max_track #(
      .IDX_W (ADDR_W)
   ) u_max_track (
      .clock      (clock),
      .scan_ctl   (scan_ctl),
      .entry      (rd_data_ff),
      .entry_idx  (pipe_idx_ff),
      .best_value (best_value),
      .best_idx   (best_idx)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pipe_valid_in  = 1'b0;
      pipe_idx_in    = pipe_idx_ff;
      cmd_in         = cmd_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[ADDR_W-1:0];
      mem_wdata.rank  = req_payload.priority_req;
      mem_wdata.value = req_payload.value;
      scan_ctl.sample = 1'b0;
      scan_ctl.first  = (pipe_idx_ff == '0);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_payload.command;
               res_value_in  = '0;
               res_status_in = uapq_pkg::STAT_OK;
               idx_in        = '0;
               state_in      = ST_FINISH;
               case (req_payload.command)
                  uapq_pkg::CMD_PUSH: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        res_status_in = uapq_pkg::STAT_FULL;
                     end
                  end
                  uapq_pkg::CMD_POP, uapq_pkg::CMD_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = uapq_pkg::STAT_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Reads are registered, so each entry reaches the comparator in the cycle after its read.
            if (issue) begin
               pipe_valid_in = 1'b1;
               pipe_idx_in   = idx_ff[ADDR_W-1:0];
               idx_in        = idx_ff + 1'b1;
            end
            scan_ctl.sample = pipe_valid_ff;
            if (drained) begin
               res_value_in = best_value;
               if (cmd_ff == uapq_pkg::CMD_POP) begin
                  idx_in   = CNT_W'(best_idx) + 1'b1;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SHIFT: begin
            // Entry read at address j is written back at j - 1 in the following cycle.
            if (issue) begin
               pipe_valid_in = 1'b1;
               pipe_idx_in   = idx_ff[ADDR_W-1:0];
               idx_in        = idx_ff + 1'b1;
            end
            if (pipe_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pipe_idx_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (drained) begin
               count_in = count_ff - 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.result_value = res_value_ff;
               rsp_payload_in.status       = res_status_ff;
               rsp_payload_in.occupancy    = uapq_pkg::occ_type'(count_ff);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pipe_idx_ff    <= pipe_idx_in;
      cmd_ff         <= cmd_in;
      res_value_ff   <= res_value_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the queue depth");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_valid_ff)
      else $error("read pipeline still busy while idle");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (count_ff != '0))
      else $error("shift started on an empty queue");

   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("finished command produced no result");

endmodule
